FILE: sv/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

	// Sizes of the managed pool and of a request
	localparam int FRAMES  = 256;
	localparam int MAX_REQ = 16;

	// Bitmap is stored as WORDS rows of WORD_W frame bits
	localparam int WORD_W  = 16;
	localparam int WORDS   = FRAMES / WORD_W;
	localparam int ADDR_W  = $clog2(WORDS);
	localparam int BIT_W   = $clog2(WORD_W);
	localparam int FRAME_W = ADDR_W + BIT_W;

	// Field widths
	localparam int CFG_W    = 9;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 3;

	// Request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd5;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Access bundle from the controller to the bitmap store
	typedef struct packed {
		logic  wr_en;
		addr_t wr_addr;
		word_t wr_data;
		logic  rd_en;
		addr_t rd_addr;
	} ram_req_t;

	// Number of set bits in one row
	function automatic logic [BIT_W:0] popcount(input word_t v);
		logic [BIT_W:0] cnt;
		cnt = '0;
		for (int i = 0; i < WORD_W; i++) begin
			cnt = cnt + (BIT_W+1)'(v[i]);
		end
		return cnt;
	endfunction

	// Position of the lowest set bit (zero when none)
	function automatic logic [BIT_W-1:0] lowest_bit(input word_t v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

FILE: sv/pfa_bitmap_ram.sv
`default_nettype none

module pfa_bitmap_ram (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfa_pkg::ram_req_t req,
	output logic [pfa_pkg::WORD_W-1:0] rd_data
);

	pfa_pkg::word_t                mem [pfa_pkg::WORDS];
	logic [pfa_pkg::WORDS-1:0]     row_valid_q;
	pfa_pkg::word_t                rd_word_s1;
	logic                          rd_valid_s1;

	// Row storage, one write and one read a cycle
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_word_s1 <= mem[req.rd_addr];
		end
	end

	// Row valid bits: an unwritten row reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				row_valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_s1 <= row_valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_s1 ? rd_word_s1 : '0;

endmodule

`default_nettype wire

FILE: sv/physical_frame_allocator.sv
`default_nettype none

// First-fit physical frame allocator. A used/free bitmap of 256 frames sits in a
// 16 x 16-bit synchronous RAM; per-row valid flops make the whole pool free at
// reset with no clearing pass. An allocate transaction (tuser 0, tdata[4:0] count)
// makes a counting pass over the managed rows to check there are enough free
// frames, then a grant pass that loads each row visited, grants its free frames
// and writes it back once it runs out of free frames or the last frame is
// granted. Too few free frames give an out of memory answer after the counting
// pass. Grants leave in ascending frame order with tlast on the final one. Free
// transactions (tuser 1, tdata[12:5] index) are a read-modify-write of one row.
// Zero, oversize and out-of-range requests answer without a pass over the
// bitmap. Holding off the output while a result waits stalls the allocator.
// frames_in_use (cfg_wr_en / cfg_wr_data) limits the managed range and may be
// written only while idle. The output register lets a new transaction be taken
// while a result waits.

module physical_frame_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_wr_en,
	input  wire logic [8:0]  cfg_wr_data,   // frames_in_use

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [4:0] frame_count, [12:5] free_index
	input  wire logic [0:0]  s_axis_tuser,  // [0] req_type

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] granted_frame
	output logic [2:0]       m_axis_tuser,  // [2:0] status
	output logic             m_axis_tlast   // last
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EMIT  = 3'd1;
	localparam logic [2:0] S_FREE  = 3'd2;
	localparam logic [2:0] S_CNT   = 3'd3;
	localparam logic [2:0] S_GLD   = 3'd4;
	localparam logic [2:0] S_GRANT = 3'd5;

	logic [2:0]                      state_q;
	logic [pfa_pkg::CFG_W-1:0]       frames_q;
	logic [pfa_pkg::COUNT_W-1:0]     count_q;
	logic [pfa_pkg::COUNT_W-1:0]     got_q;
	logic [pfa_pkg::CFG_W-1:0]       nfree_q;
	pfa_pkg::addr_t                  row_q;
	logic [pfa_pkg::BIT_W-1:0]       bit_q;
	pfa_pkg::word_t                  word_q;
	logic [pfa_pkg::STATUS_W-1:0]    stat_q;

	logic                            out_valid_q;
	logic [pfa_pkg::FRAME_W-1:0]     out_frame_q;
	logic [pfa_pkg::STATUS_W-1:0]    out_status_q;
	logic                            out_last_q;

	pfa_pkg::ram_req_t               ram_req;
	pfa_pkg::word_t                  rd_data;

	logic                            in_fire;
	logic                            can_emit;
	logic [pfa_pkg::CFG_W-1:0]       limit;
	logic [pfa_pkg::FRAME_W-1:0]     lm1;
	pfa_pkg::addr_t                  last_row;
	pfa_pkg::word_t                  row_mask;
	pfa_pkg::word_t                  cnt_free;
	logic [pfa_pkg::CFG_W-1:0]       nfree_next;
	pfa_pkg::word_t                  grant_free;
	logic [pfa_pkg::BIT_W-1:0]       grant_bit;
	pfa_pkg::word_t                  grant_hot;
	logic                            grant_last;
	logic [pfa_pkg::COUNT_W-1:0]     in_count;
	logic [pfa_pkg::FRAME_W-1:0]     in_index;
	logic                            in_kind;

	logic                            emit_en;
	logic [pfa_pkg::FRAME_W-1:0]     emit_frame;
	logic [pfa_pkg::STATUS_W-1:0]    emit_status;
	logic                            emit_last;

	assign in_kind  = s_axis_tuser[0];
	assign in_count = s_axis_tdata[pfa_pkg::COUNT_W-1:0];
	assign in_index = s_axis_tdata[pfa_pkg::COUNT_W +: pfa_pkg::FRAME_W];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign can_emit      = !out_valid_q || m_axis_tready;

	// Effective managed range and the mask of managed bits in the current row
	assign limit    = (frames_q > pfa_pkg::CFG_W'(pfa_pkg::FRAMES))
	                  ? pfa_pkg::CFG_W'(pfa_pkg::FRAMES) : frames_q;
	assign lm1      = pfa_pkg::FRAME_W'(limit - pfa_pkg::CFG_W'(1));
	assign last_row = lm1[pfa_pkg::FRAME_W-1:pfa_pkg::BIT_W];

	always_comb begin
		for (int b = 0; b < pfa_pkg::WORD_W; b++) begin
			row_mask[b] = (row_q != last_row) ||
			              (pfa_pkg::BIT_W'(b) <= lm1[pfa_pkg::BIT_W-1:0]);
		end
	end

	// Counting pass accumulation
	assign cnt_free   = ~rd_data & row_mask;
	assign nfree_next = nfree_q + pfa_pkg::CFG_W'(pfa_pkg::popcount(cnt_free));

	// Grant pick within the loaded row
	assign grant_free = ~word_q & row_mask;
	assign grant_bit  = pfa_pkg::lowest_bit(grant_free);
	assign grant_hot  = pfa_pkg::word_t'(1) << grant_bit;
	assign grant_last = ((got_q + pfa_pkg::COUNT_W'(1)) == count_q);

	// Sequencer and RAM accesses
	always_comb begin
		ram_req     = '0;
		emit_en     = 1'b0;
		emit_frame  = '0;
		emit_status = stat_q;
		emit_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = (in_kind == pfa_pkg::REQ_FREE)
					                  ? in_index[pfa_pkg::FRAME_W-1:pfa_pkg::BIT_W] : '0;
				end
			end
			S_EMIT: begin
				emit_en = can_emit;
			end
			S_FREE: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = row_q;
				ram_req.wr_data = rd_data & ~(pfa_pkg::word_t'(1) << bit_q);
			end
			S_CNT: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = (row_q == last_row) ? '0 : row_q + pfa_pkg::addr_t'(1);
			end
			S_GRANT: begin
				if (grant_free == '0) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = row_q;
					ram_req.wr_data = word_q;
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = row_q + pfa_pkg::addr_t'(1);
				end else if (can_emit) begin
					emit_en     = 1'b1;
					emit_frame  = {row_q, grant_bit};
					emit_status = pfa_pkg::ST_GRANTED;
					emit_last   = grant_last;
					if (grant_last) begin
						ram_req.wr_en   = 1'b1;
						ram_req.wr_addr = row_q;
						ram_req.wr_data = word_q | grant_hot;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			frames_q <= pfa_pkg::CFG_W'(pfa_pkg::FRAMES);
		end else begin
			if (cfg_wr_en) begin
				frames_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_kind == pfa_pkg::REQ_FREE) begin
							if ({1'b0, in_index} >= limit) begin
								state_q <= S_EMIT;
							end else begin
								state_q <= S_FREE;
							end
						end else if (in_count > pfa_pkg::COUNT_W'(pfa_pkg::MAX_REQ) ||
						             in_count == '0 || limit == '0) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_CNT;
						end
					end
				end
				S_EMIT: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				S_FREE: begin
					state_q <= S_EMIT;
				end
				S_CNT: begin
					if (row_q == last_row) begin
						state_q <= (nfree_next < pfa_pkg::CFG_W'(count_q)) ? S_EMIT : S_GLD;
					end
				end
				S_GLD: begin
					state_q <= S_GRANT;
				end
				S_GRANT: begin
					if (grant_free == '0) begin
						state_q <= S_GLD;
					end else if (can_emit && grant_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current request
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				count_q <= in_count;
				got_q   <= '0;
				nfree_q <= '0;
				// allocations scan from row zero
				row_q   <= (in_kind == pfa_pkg::REQ_FREE)
				           ? in_index[pfa_pkg::FRAME_W-1:pfa_pkg::BIT_W] : '0;
				bit_q   <= in_index[pfa_pkg::BIT_W-1:0];
				if (in_kind == pfa_pkg::REQ_FREE) begin
					stat_q <= ({1'b0, in_index} >= limit) ? pfa_pkg::ST_BAD_INDEX
					                                      : pfa_pkg::ST_FREED;
				end else if (in_count > pfa_pkg::COUNT_W'(pfa_pkg::MAX_REQ)) begin
					stat_q <= pfa_pkg::ST_TOO_LARGE;
				end else if (in_count == '0) begin
					stat_q <= pfa_pkg::ST_EMPTY;
				end else begin
					stat_q <= pfa_pkg::ST_OOM;
				end
			end
			S_CNT: begin
				nfree_q <= nfree_next;
				row_q   <= (row_q == last_row) ? '0 : row_q + pfa_pkg::addr_t'(1);
			end
			S_GLD: begin
				word_q <= rd_data;
			end
			S_GRANT: begin
				if (grant_free == '0) begin
					row_q <= row_q + pfa_pkg::addr_t'(1);
				end else if (can_emit) begin
					word_q <= word_q | grant_hot;
					got_q  <= got_q + pfa_pkg::COUNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			out_frame_q  <= emit_frame;
			out_status_q <= emit_status;
			out_last_q   <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_frame_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	pfa_bitmap_ram u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire
